// ----- design/iou_nms_pkg.sv -----
// Package for the IoU non-maximum suppression block: widths, types and helpers.
// Used by the cell and the top level; no dependencies.
package iou_nms_pkg;

  localparam int MAX_KEPT_DEF        = 64;
  localparam int COORD_FRAC_BITS_DEF = 4;
  localparam int CoordW              = 16;
  localparam int SizeW               = 15;
  localparam int AreaW               = 30;
  localparam int ThrW                = 16;
  localparam int SlotW               = 6;
  localparam logic [ThrW-1:0] ThrReset = 16'd29491;

  typedef struct packed {
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] top;
    logic [SizeW-1:0]         width;
    logic [SizeW-1:0]         height;
  } box_t;

  // Probe travelling down the chain, compared against each cell's stored box.
  typedef struct packed {
    box_t             box;
    logic [AreaW-1:0] area;
    logic             last;
    logic             hit;
  } probe_t;

  // Overlap length of [a0, a0+aw) and [b0, b0+bw), zero when disjoint.
  function automatic logic [SizeW-1:0] overlap(
      input logic signed [CoordW-1:0] a0, input logic [SizeW-1:0] aw,
      input logic signed [CoordW-1:0] b0, input logic [SizeW-1:0] bw);
    logic signed [CoordW+1:0] a1;
    logic signed [CoordW+1:0] b1;
    logic signed [CoordW+1:0] lo;
    logic signed [CoordW+1:0] hi;
    logic signed [CoordW+1:0] d;
    a1 = {{2{a0[CoordW-1]}}, a0} + $signed({3'b000, aw});
    b1 = {{2{b0[CoordW-1]}}, b0} + $signed({3'b000, bw});
    lo = (a0 > b0) ? {{2{a0[CoordW-1]}}, a0} : {{2{b0[CoordW-1]}}, b0};
    hi = (a1 < b1) ? a1 : b1;
    d  = hi - lo;
    overlap = (hi > lo) ? d[SizeW-1:0] : '0;
  endfunction

endpackage

// ----- design/iou_nms_cell.sv -----
// One table cell: holds a kept box and its area, tests the passing probe.
// Depends on iou_nms_pkg. Two register stages: overlap product, then compare.
module iou_nms_cell
  import iou_nms_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic [ThrW-1:0] thr,
  input  logic            in_vld,
  input  probe_t          in_probe,
  input  logic            wr_en,
  input  box_t            wr_box,
  input  logic [AreaW-1:0] wr_area,
  input  logic            occ,
  output logic            out_vld,
  output probe_t          out_probe
);

  box_t             box_r;
  logic [AreaW-1:0] area_r;
  logic             s1_vld_r, s1_occ_r;
  probe_t           s1_probe_r;
  logic [AreaW-1:0] s1_inter_r, s1_karea_r;
  logic             s2_vld_r;
  probe_t           s2_probe_r;
  probe_t           s2_probe_nxt;
  logic [SizeW-1:0] iw, ih;
  logic [AreaW:0]   uni;
  logic [AreaW+16:0] lhs, rhs;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      box_r  <= wr_box;
      area_r <= wr_area;
    end
  end

  assign iw = overlap(in_probe.box.left, in_probe.box.width, box_r.left, box_r.width);
  assign ih = overlap(in_probe.box.top, in_probe.box.height, box_r.top, box_r.height);

  // Mark the probe once it is suppressed by an occupied cell
  always_comb begin
    s2_probe_nxt = s1_probe_r;
    if (s1_occ_r && (lhs > rhs)) s2_probe_nxt.hit = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
    s1_probe_r <= in_probe;
    s1_occ_r   <= occ;
    s1_inter_r <= iw * ih;
    s1_karea_r <= area_r;
    s2_probe_r <= s2_probe_nxt;
  end

  assign uni = {1'b0, s1_probe_r.area} + {1'b0, s1_karea_r} - {1'b0, s1_inter_r};
  assign lhs = {1'b0, s1_inter_r, 16'd0};
  assign rhs = (AreaW+17)'(uni * thr);

  assign out_vld   = s2_vld_r;
  assign out_probe = s2_probe_r;

endmodule

// ----- design/iou_non_max_suppression_top.sv -----
// Top level of greedy IoU non-maximum suppression: chain of table cells.
// Depends on iou_nms_pkg and iou_nms_cell.
// Each box passes both register stages of every cell, then the output register;
// one box at a time: a new box is accepted only once the previous result has
// been taken, so an output stall holds off the input.
// Reset: kept count cleared, threshold 29491; table contents undefined until written.
module iou_non_max_suppression_top
  import iou_nms_pkg::*;
#(
  parameter int MAX_KEPT        = MAX_KEPT_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // box_left, box_top, box_width, box_height, pad
  input  logic        s_axis_tlast,  // last_box
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // kept, kept_slot, pad
  output logic        m_axis_tuser,  // table_full
  output logic        m_axis_tlast   // frame_end
);

  localparam int CntW = $clog2(MAX_KEPT + 1);
  localparam int IdxW = $clog2(MAX_KEPT);

  logic [ThrW-1:0] thr_r;
  logic [CntW-1:0] cnt_r;
  logic            busy_r, ovld_r;
  logic [7:0]      odata_r;
  logic            ouser_r;
  logic            olast_r;
  probe_t          head;
  logic            vld  [MAX_KEPT+1];
  probe_t          prb  [MAX_KEPT+1];
  logic            keep, full, done;
  logic [IdxW-1:0] widx;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= ThrReset;
    else if (cfg_valid) thr_r <= cfg_data;
  end

  assign s_axis_tready = !busy_r && !ovld_r;
  assign head.box.left   = s_axis_tdata[15:0];
  assign head.box.top    = s_axis_tdata[31:16];
  assign head.box.width  = s_axis_tdata[46:32];
  assign head.box.height = s_axis_tdata[61:47];
  assign head.area = AreaW'(head.box.width * head.box.height);
  assign head.last = s_axis_tlast;
  assign head.hit  = 1'b0;
  assign vld[0] = s_axis_tvalid && s_axis_tready;
  assign prb[0] = head;

  for (genvar g = 0; g < MAX_KEPT; g++) begin : g_cell
    iou_nms_cell u_cell (
      .clk, .rst_n, .thr(thr_r),
      .in_vld(vld[g]), .in_probe(prb[g]),
      .wr_en(done && keep && !full && widx == IdxW'(g)),
      .wr_box(prb[MAX_KEPT].box), .wr_area(prb[MAX_KEPT].area),
      .occ(cnt_r > CntW'(g)),
      .out_vld(vld[g+1]), .out_probe(prb[g+1])
    );
  end

  assign done = vld[MAX_KEPT];
  assign keep = !prb[MAX_KEPT].hit;
  assign full = cnt_r >= CntW'(MAX_KEPT);
  assign widx = cnt_r[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ovld_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (vld[0]) busy_r <= 1'b1;
      if (done) begin
        busy_r <= 1'b0;
        ovld_r <= 1'b1;
        if (prb[MAX_KEPT].last) cnt_r <= '0;
        else if (keep && !full) cnt_r <= cnt_r + CntW'(1);
      end else if (m_axis_tready) begin
        ovld_r <= 1'b0;
      end
    end
    if (done) begin
      odata_r <= {1'b0, (keep && !full) ? SlotW'(cnt_r) : SlotW'(0), keep};
      ouser_r <= keep && full;
      olast_r <= prb[MAX_KEPT].last;
    end
  end

  assign m_axis_tvalid = ovld_r;
  assign m_axis_tdata  = odata_r;
  assign m_axis_tuser  = ouser_r;
  assign m_axis_tlast  = olast_r;

  assert property (@(posedge clk) disable iff (!rst_n) done |-> busy_r);
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CntW'(MAX_KEPT));
  assert property (@(posedge clk) disable iff (!rst_n) vld[0] |=> !s_axis_tready);
  assert property (@(posedge clk) disable iff (!rst_n)
    (m_axis_tvalid && m_axis_tdata[0] == 1'b0) |-> m_axis_tdata[6:1] == '0);

endmodule
